FILE: hw/rtl/c8i_pkg.sv
`timescale 1ns / 1ps
package c8i_pkg;

   localparam int STACK_DEPTH_DEF = 12;
   localparam int MEM_BYTES       = 4096;
   localparam int MEM_AW          = 12;
   localparam int DISP_BYTES      = 256;
   localparam int DISP_AW         = 8;
   localparam logic [11:0] FONT_BASE = 12'h124;
   localparam logic [11:0] FONT_END  = 12'h174;
   localparam logic [7:0]  BOOT_BYTE = 8'h12;

   typedef enum logic [2:0] {
      REQ_LOAD  = 3'd0,
      REQ_EXEC  = 3'd1,
      REQ_KEY   = 3'd2,
      REQ_TICK  = 3'd3,
      REQ_READ  = 3'd4
   } req_code_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISP_RD, ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y,
      ST_EXEC, ST_DRAW_CHK, ST_DRAW_MEM, ST_DRAW_RD1, ST_DRAW_WR1, ST_DRAW_RD2,
      ST_DRAW_WR2, ST_DRAW_FLAG, ST_BCD_1, ST_BCD_2, ST_STORE, ST_LOAD_RD,
      ST_LOAD_WR, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SUBN, ALU_SHR, ALU_SHL
   } alu_op_type;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SE   = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LDK  = 4'h6;
   localparam logic [3:0] OP_ADDK = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV0 = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_KEY  = 4'hE;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [11:0] SYS_CLS = 12'h0E0;
   localparam logic [11:0] SYS_RET = 12'h0EE;
   localparam logic [7:0]  KEY_SKP  = 8'h9E;
   localparam logic [7:0]  KEY_SKNP = 8'hA1;
   localparam logic [7:0]  F_GETDT = 8'h07;
   localparam logic [7:0]  F_WAIT  = 8'h0A;
   localparam logic [7:0]  F_SETDT = 8'h15;
   localparam logic [7:0]  F_SETST = 8'h18;
   localparam logic [7:0]  F_ADDI  = 8'h1E;
   localparam logic [7:0]  F_FONT  = 8'h29;
   localparam logic [7:0]  F_BCD   = 8'h33;
   localparam logic [7:0]  F_STORE = 8'h55;
   localparam logic [7:0]  F_LOAD  = 8'h65;

   function automatic logic [19:0] glyph(input logic [3:0] g);
      logic [19:0] v;
      unique case (g)
         4'h0: v = 20'hF999F;  4'h1: v = 20'h26227;
         4'h2: v = 20'hF1F8F;  4'h3: v = 20'hF1F1F;
         4'h4: v = 20'h99F11;  4'h5: v = 20'hF8F1F;
         4'h6: v = 20'hF8F9F;  4'h7: v = 20'hF1244;
         4'h8: v = 20'hF9F9F;  4'h9: v = 20'hF9F1F;
         4'hA: v = 20'hF9F99;  4'hB: v = 20'hE9E9E;
         4'hC: v = 20'hF888F;  4'hD: v = 20'hE999E;
         4'hE: v = 20'hF8F8F;  default: v = 20'hF8F88;
      endcase
      return v;
   endfunction

   // Row r of glyph g, pixels in the high nibble.
   function automatic logic [7:0] font_row(input logic [3:0] g, input logic [2:0] r);
      logic [19:0] v;
      logic [3:0]  nib;
      v = glyph(g);
      unique case (r)
         3'd0: nib = v[19:16];
         3'd1: nib = v[15:12];
         3'd2: nib = v[11:8];
         3'd3: nib = v[7:4];
         default: nib = v[3:0];
      endcase
      return {nib, 4'h0};
   endfunction

   function automatic logic [7:0] bcd_rem(input logic [7:0] v);
      logic [7:0] r;
      if (v >= 8'd200) r = v - 8'd200;
      else if (v >= 8'd100) r = v - 8'd100;
      else r = v;
      return r;
   endfunction

   function automatic logic [7:0] bcd_hundreds(input logic [7:0] v);
      logic [7:0] h;
      if (v >= 8'd200) h = 8'd2;
      else if (v >= 8'd100) h = 8'd1;
      else h = 8'd0;
      return h;
   endfunction

   // Remainder is below 100, where multiplying by 103 and dropping ten bits is exact.
   function automatic logic [7:0] bcd_tens(input logic [7:0] v);
      logic [14:0] p;
      p = 15'(bcd_rem(v)) * 15'd103;
      return 8'(p[14:10]);
   endfunction

   function automatic logic [7:0] bcd_ones(input logic [7:0] v);
      logic [7:0] t;
      t = bcd_tens(v);
      return bcd_rem(v) - 8'((t << 3) + (t << 1));
   endfunction

endpackage

FILE: hw/rtl/chip8_interpreter_core.sv
`timescale 1ns / 1ps
// Load, key, tick and unknown items give their result in the cycle after acceptance; a display
// read adds a display read state. An instruction fetches two bytes, reads Vx and Vy and executes;
// a draw adds per row a check, a sprite read and a read and write of two display bytes, then a
// check and a flag write; Fx55 adds a store per register to Vx, Fx65 a read and a write each and
// Fx33 two writes. The block takes the next item once the result has been taken. After reset an
// initialisation pass writes all 4096 bytes of program memory before the first item is accepted.
module chip8_interpreter_core #(
   parameter int STACK_DEPTH = c8i_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // addr[11:0], wdata[19:12], key_index[23:20], key_down[24], random_byte[32:25]
   input  logic [39:0] req_tdata,
   // req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], waiting_key[8], sound_on[9], program_counter[25:10], executed[26]
   output logic [31:0] rsp_tdata
);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SW-1:0] SI_LAST = SW'(STACK_DEPTH - 1);
   localparam logic [SW-1:0] SI_WRAP = SW'(255 % STACK_DEPTH);

   c8i_pkg::state_type state_ff, state_in;
   logic [11:0] clr_addr_ff, clr_addr_in;
   logic [3:0]  font_g_ff, font_g_in;
   logic [2:0]  font_r_ff, font_r_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [7:0]  op_hi_ff, op_hi_in, op_lo_ff, op_lo_in;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [15:0] pc_ff, pc_in, i_ff, i_in;
   logic [7:0]  sp_ff, sp_in;
   logic [SW-1:0] si_ff, si_in;
   logic [7:0]  delay_ff, delay_in, sound_ff, sound_in;
   logic [15:0] keys_ff, keys_in;
   logic        wait_ff, wait_in;
   logic [3:0]  target_ff, target_in;
   logic [3:0]  row_ff, row_in;
   logic        hit_ff, hit_in;
   logic [7:0]  spr_ff, spr_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  rd_ff, rd_in;
   logic        exec_ff, exec_in;
   logic [7:0]  regs_ff [16];
   logic [15:0] stack_ff [STACK_DEPTH];
   logic [c8i_pkg::DISP_BYTES-1:0] disp_valid_ff;

   logic        reg_we, flag_we, stack_we, disp_clear;
   logic [3:0]  reg_widx;
   logic [7:0]  reg_wdata;
   logic        flag_wdata;

   logic        mem_we;
   logic [11:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata, mem_rdata;
   logic        disp_we;
   logic [7:0]  disp_waddr, disp_raddr, disp_wdata, disp_rdata;

   logic        req_fire;
   logic [2:0]  req_kind;
   logic [3:0]  u, x, y, n;
   logic [7:0]  kk;
   logic [11:0] nnn;
   logic [3:0]  rd_idx;
   logic [7:0]  rval;
   logic        alu_ok, alu_flag_ok;
   c8i_pkg::alu_op_type alu_op;
   logic [7:0]  alu_b, alu_res;
   logic        alu_flag;
   logic [4:0]  row_y;
   logic [7:0]  vx7;
   logic [7:0]  disp_b1, disp_b2;
   logic [15:0] spr_wide;
   logic [7:0]  old_byte, new_bits;
   logic [12:0] i_sum;
   logic        in_font;

   assign req_tready = (state_ff == c8i_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = req_tuser;
   assign rsp_tvalid = (state_ff == c8i_pkg::ST_RESP);
   assign rsp_tdata  = {5'b0, exec_ff, pc_ff, (sound_ff != 8'd0), wait_ff, rd_ff};

   assign u   = op_hi_ff[7:4];
   assign x   = op_hi_ff[3:0];
   assign y   = op_lo_ff[7:4];
   assign n   = op_lo_ff[3:0];
   assign kk  = op_lo_ff;
   assign nnn = {op_hi_ff[3:0], op_lo_ff};

   always_comb begin
      if (state_ff == c8i_pkg::ST_READ_X) begin
         rd_idx = (u == c8i_pkg::OP_JPV0) ? 4'd0 : x;
      end else if (state_ff == c8i_pkg::ST_READ_Y) begin
         rd_idx = y;
      end else begin
         rd_idx = cnt_ff;
      end
   end
   assign rval = regs_ff[rd_idx];

   always_comb begin
      alu_ok = 1'b1;
      alu_flag_ok = 1'b1;
      unique case (n)
         4'h0: begin alu_op = c8i_pkg::ALU_MOV; alu_flag_ok = 1'b0; end
         4'h1: begin alu_op = c8i_pkg::ALU_OR;  alu_flag_ok = 1'b0; end
         4'h2: begin alu_op = c8i_pkg::ALU_AND; alu_flag_ok = 1'b0; end
         4'h3: begin alu_op = c8i_pkg::ALU_XOR; alu_flag_ok = 1'b0; end
         4'h4: alu_op = c8i_pkg::ALU_ADD;
         4'h5: alu_op = c8i_pkg::ALU_SUB;
         4'h6: alu_op = c8i_pkg::ALU_SHR;
         4'h7: alu_op = c8i_pkg::ALU_SUBN;
         4'hE: alu_op = c8i_pkg::ALU_SHL;
         default: begin alu_op = c8i_pkg::ALU_MOV; alu_ok = 1'b0; alu_flag_ok = 1'b0; end
      endcase
      if (u == c8i_pkg::OP_ADDK) begin
         alu_op = c8i_pkg::ALU_ADD;
      end
   end
   assign alu_b = (u == c8i_pkg::OP_ADDK) ? kk : vy_ff;

   c8i_alu u_alu (
      .op   (alu_op),
      .a    (vx_ff),
      .b    (alu_b),
      .res  (alu_res),
      .flag (alu_flag)
   );

   // Sprite geometry: rows wrap at 32, bytes wrap at 64 pixels across.
   assign row_y    = vy_ff[4:0] + {1'b0, row_ff};
   assign vx7      = vx_ff + 8'd7;
   assign disp_b1  = {row_y, vx_ff[5:3]};
   assign disp_b2  = {row_y, vx7[5:3]};
   assign spr_wide = {spr_ff, 8'h00} >> vx_ff[2:0];
   assign i_sum    = {1'b0, i_ff[11:0]} + {5'b0, vx_ff};
   assign in_font  = (clr_addr_ff >= c8i_pkg::FONT_BASE) && (clr_addr_ff < c8i_pkg::FONT_END);

   always_comb begin
      if (state_ff == c8i_pkg::ST_DRAW_WR1) begin
         old_byte = disp_valid_ff[disp_b1] ? disp_rdata : 8'h00;
         new_bits = spr_wide[15:8];
      end else begin
         old_byte = disp_valid_ff[disp_b2] ? disp_rdata : 8'h00;
         new_bits = spr_wide[7:0];
      end
   end

   c8i_ram #(.WIDTH(8), .DEPTH(c8i_pkg::MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   c8i_ram #(.WIDTH(8), .DEPTH(c8i_pkg::DISP_BYTES)) u_disp (
      .clock (clock),
      .we    (disp_we),
      .waddr (disp_waddr),
      .wdata (disp_wdata),
      .raddr (disp_raddr),
      .rdata (disp_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         c8i_pkg::ST_CLEAR:
            if (clr_addr_ff == 12'hFFF) state_in = c8i_pkg::ST_IDLE;
         c8i_pkg::ST_IDLE:
            if (req_fire) begin
               if (req_kind == c8i_pkg::REQ_EXEC && !wait_ff) begin
                  state_in = c8i_pkg::ST_FETCH_HI;
               end else if (req_kind == c8i_pkg::REQ_READ) begin
                  state_in = c8i_pkg::ST_DISP_RD;
               end else begin
                  state_in = c8i_pkg::ST_RESP;
               end
            end
         c8i_pkg::ST_DISP_RD:  state_in = c8i_pkg::ST_RESP;
         c8i_pkg::ST_FETCH_HI: state_in = c8i_pkg::ST_FETCH_LO;
         c8i_pkg::ST_FETCH_LO: state_in = c8i_pkg::ST_READ_X;
         c8i_pkg::ST_READ_X:   state_in = c8i_pkg::ST_READ_Y;
         c8i_pkg::ST_READ_Y:   state_in = c8i_pkg::ST_EXEC;
         c8i_pkg::ST_EXEC: begin
            state_in = c8i_pkg::ST_RESP;
            if (u == c8i_pkg::OP_DRW) begin
               state_in = c8i_pkg::ST_DRAW_CHK;
            end else if (u == c8i_pkg::OP_MISC) begin
               if (kk == c8i_pkg::F_BCD)   state_in = c8i_pkg::ST_BCD_1;
               if (kk == c8i_pkg::F_STORE) state_in = c8i_pkg::ST_STORE;
               if (kk == c8i_pkg::F_LOAD)  state_in = c8i_pkg::ST_LOAD_RD;
            end
         end
         c8i_pkg::ST_DRAW_CHK:
            state_in = (row_ff == 4'd0) ? c8i_pkg::ST_DRAW_FLAG : c8i_pkg::ST_DRAW_MEM;
         c8i_pkg::ST_DRAW_MEM:  state_in = c8i_pkg::ST_DRAW_RD1;
         c8i_pkg::ST_DRAW_RD1:  state_in = c8i_pkg::ST_DRAW_WR1;
         c8i_pkg::ST_DRAW_WR1:  state_in = c8i_pkg::ST_DRAW_RD2;
         c8i_pkg::ST_DRAW_RD2:  state_in = c8i_pkg::ST_DRAW_WR2;
         c8i_pkg::ST_DRAW_WR2:  state_in = c8i_pkg::ST_DRAW_CHK;
         c8i_pkg::ST_DRAW_FLAG: state_in = c8i_pkg::ST_RESP;
         c8i_pkg::ST_BCD_1:     state_in = c8i_pkg::ST_BCD_2;
         c8i_pkg::ST_BCD_2:     state_in = c8i_pkg::ST_RESP;
         c8i_pkg::ST_STORE:
            if (cnt_ff == x) state_in = c8i_pkg::ST_RESP;
         c8i_pkg::ST_LOAD_RD:   state_in = c8i_pkg::ST_LOAD_WR;
         c8i_pkg::ST_LOAD_WR:
            state_in = (cnt_ff == x) ? c8i_pkg::ST_RESP : c8i_pkg::ST_LOAD_RD;
         c8i_pkg::ST_RESP:
            if (rsp_tready) state_in = c8i_pkg::ST_IDLE;
         default: state_in = c8i_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      font_g_in = font_g_ff;
      font_r_in = font_r_ff;
      addr_in = addr_ff;
      rnd_in = rnd_ff;
      op_hi_in = op_hi_ff;
      op_lo_in = op_lo_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      pc_in = pc_ff;
      i_in = i_ff;
      sp_in = sp_ff;
      si_in = si_ff;
      delay_in = delay_ff;
      sound_in = sound_ff;
      keys_in = keys_ff;
      wait_in = wait_ff;
      target_in = target_ff;
      row_in = row_ff;
      hit_in = hit_ff;
      spr_in = spr_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      exec_in = exec_ff;
      reg_we = 1'b0;
      reg_widx = x;
      reg_wdata = alu_res;
      flag_we = 1'b0;
      flag_wdata = alu_flag;
      stack_we = 1'b0;
      disp_clear = 1'b0;
      mem_we = 1'b0;
      mem_waddr = i_ff[11:0];
      mem_wdata = rval;
      mem_raddr = pc_ff[11:0];
      disp_we = 1'b0;
      disp_waddr = disp_b1;
      disp_wdata = old_byte ^ new_bits;
      disp_raddr = disp_b1;

      unique case (state_ff)
         c8i_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = 8'h00;
            if (clr_addr_ff == 12'd0) begin
               mem_wdata = c8i_pkg::BOOT_BYTE;
            end else if (in_font) begin
               mem_wdata = c8i_pkg::font_row(font_g_ff, font_r_ff);
               if (font_r_ff == 3'd4) begin
                  font_r_in = 3'd0;
                  font_g_in = font_g_ff + 4'd1;
               end else begin
                  font_r_in = font_r_ff + 3'd1;
               end
            end
            clr_addr_in = clr_addr_ff + 12'd1;
         end
         c8i_pkg::ST_IDLE: begin
            disp_raddr = req_tdata[7:0];
            if (req_fire) begin
               addr_in = req_tdata[11:0];
               rnd_in = req_tdata[32:25];
               rd_in = 8'h00;
               exec_in = 1'b0;
               unique case (req_kind)
                  c8i_pkg::REQ_LOAD: begin
                     mem_we = 1'b1;
                     mem_waddr = req_tdata[11:0];
                     mem_wdata = req_tdata[19:12];
                  end
                  c8i_pkg::REQ_EXEC: exec_in = !wait_ff;
                  c8i_pkg::REQ_KEY: begin
                     keys_in[req_tdata[23:20]] = req_tdata[24];
                     if (req_tdata[24] && wait_ff) begin
                        wait_in = 1'b0;
                        reg_we = 1'b1;
                        reg_widx = target_ff;
                        reg_wdata = {4'h0, req_tdata[23:20]};
                     end
                  end
                  c8i_pkg::REQ_TICK: begin
                     if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
                     if (sound_ff != 8'd0) sound_in = sound_ff - 8'd1;
                  end
                  default: ;
               endcase
            end
         end
         c8i_pkg::ST_DISP_RD:
            rd_in = disp_valid_ff[addr_ff[7:0]] ? disp_rdata : 8'h00;
         c8i_pkg::ST_FETCH_HI: mem_raddr = pc_ff[11:0];
         c8i_pkg::ST_FETCH_LO: begin
            mem_raddr = pc_ff[11:0] + 12'd1;
            op_hi_in = mem_rdata;
         end
         c8i_pkg::ST_READ_X: begin
            op_lo_in = mem_rdata;
            vx_in = rval;
         end
         c8i_pkg::ST_READ_Y: begin
            vy_in = rval;
            pc_in = pc_ff + 16'd2;
         end
         c8i_pkg::ST_EXEC: begin
            unique case (u)
               c8i_pkg::OP_SYS:
                  if (nnn == c8i_pkg::SYS_CLS) begin
                     disp_clear = 1'b1;
                  end else if (nnn == c8i_pkg::SYS_RET) begin
                     pc_in = stack_ff[si_ff];
                     sp_in = sp_ff - 8'd1;
                     if (sp_ff == 8'd0) si_in = SI_WRAP;
                     else si_in = (si_ff == '0) ? SI_LAST : si_ff - SW'(1);
                  end
               c8i_pkg::OP_JP: pc_in = {4'h0, nnn};
               c8i_pkg::OP_CALL: begin
                  sp_in = sp_ff + 8'd1;
                  if (sp_ff == 8'hFF) si_in = '0;
                  else si_in = (si_ff == SI_LAST) ? '0 : si_ff + SW'(1);
                  stack_we = 1'b1;
                  pc_in = {4'h0, nnn};
               end
               c8i_pkg::OP_SE:   if (vx_ff == kk) pc_in = pc_ff + 16'd2;
               c8i_pkg::OP_SNE:  if (vx_ff != kk) pc_in = pc_ff + 16'd2;
               c8i_pkg::OP_SER:  if (n == 4'h0 && vx_ff == vy_ff) pc_in = pc_ff + 16'd2;
               c8i_pkg::OP_SNER: if (n == 4'h0 && vx_ff != vy_ff) pc_in = pc_ff + 16'd2;
               c8i_pkg::OP_LDK: begin
                  reg_we = 1'b1;
                  reg_wdata = kk;
               end
               c8i_pkg::OP_ADDK: reg_we = 1'b1;
               c8i_pkg::OP_ALU: begin
                  reg_we = alu_ok;
                  flag_we = alu_flag_ok;
               end
               c8i_pkg::OP_LDI:  i_in = {4'h0, nnn};
               c8i_pkg::OP_JPV0: pc_in = {4'h0, nnn} + {8'h00, vx_ff};
               c8i_pkg::OP_RND: begin
                  reg_we = 1'b1;
                  reg_wdata = rnd_ff & kk;
               end
               c8i_pkg::OP_DRW: begin
                  row_in = n;
                  hit_in = 1'b0;
               end
               c8i_pkg::OP_KEY: begin
                  if (kk == c8i_pkg::KEY_SKP && keys_ff[vx_ff[3:0]]) pc_in = pc_ff + 16'd2;
                  else if (kk == c8i_pkg::KEY_SKNP && !keys_ff[vx_ff[3:0]])
                     pc_in = pc_ff + 16'd2;
               end
               default: begin
                  unique case (kk)
                     c8i_pkg::F_GETDT: begin
                        reg_we = 1'b1;
                        reg_wdata = delay_ff;
                     end
                     c8i_pkg::F_WAIT: begin
                        wait_in = 1'b1;
                        target_in = x;
                     end
                     c8i_pkg::F_SETDT: delay_in = vx_ff;
                     c8i_pkg::F_SETST: sound_in = vx_ff;
                     c8i_pkg::F_ADDI: begin
                        flag_we = 1'b1;
                        flag_wdata = i_sum[12];
                        i_in = {3'b000, i_sum};
                     end
                     c8i_pkg::F_FONT:
                        i_in = {4'h0, c8i_pkg::FONT_BASE} + {10'd0, vx_ff[3:0], 2'b00}
                             + {12'd0, vx_ff[3:0]};
                     c8i_pkg::F_BCD: begin
                        mem_we = 1'b1;
                        mem_wdata = c8i_pkg::bcd_hundreds(vx_ff);
                     end
                     c8i_pkg::F_STORE: cnt_in = 4'd0;
                     c8i_pkg::F_LOAD:  cnt_in = 4'd0;
                     default: ;
                  endcase
               end
            endcase
         end
         c8i_pkg::ST_DRAW_CHK:
            if (row_ff != 4'd0) row_in = row_ff - 4'd1;
         c8i_pkg::ST_DRAW_MEM: mem_raddr = i_ff[11:0] + {8'h00, row_ff};
         c8i_pkg::ST_DRAW_RD1: begin
            spr_in = mem_rdata;
            disp_raddr = disp_b1;
         end
         c8i_pkg::ST_DRAW_WR1: begin
            disp_we = 1'b1;
            disp_waddr = disp_b1;
            hit_in = hit_ff | (|(old_byte & new_bits));
         end
         c8i_pkg::ST_DRAW_RD2: disp_raddr = disp_b2;
         c8i_pkg::ST_DRAW_WR2: begin
            disp_we = 1'b1;
            disp_waddr = disp_b2;
            hit_in = hit_ff | (|(old_byte & new_bits));
         end
         c8i_pkg::ST_DRAW_FLAG: begin
            flag_we = 1'b1;
            flag_wdata = hit_ff;
         end
         c8i_pkg::ST_BCD_1: begin
            mem_we = 1'b1;
            mem_waddr = i_ff[11:0] + 12'd1;
            mem_wdata = c8i_pkg::bcd_tens(vx_ff);
         end
         c8i_pkg::ST_BCD_2: begin
            mem_we = 1'b1;
            mem_waddr = i_ff[11:0] + 12'd2;
            mem_wdata = c8i_pkg::bcd_ones(vx_ff);
         end
         c8i_pkg::ST_STORE: begin
            mem_we = 1'b1;
            i_in = i_ff + 16'd1;
            cnt_in = cnt_ff + 4'd1;
         end
         c8i_pkg::ST_LOAD_RD: mem_raddr = i_ff[11:0];
         c8i_pkg::ST_LOAD_WR: begin
            reg_we = 1'b1;
            reg_widx = cnt_ff;
            reg_wdata = mem_rdata;
            i_in = i_ff + 16'd1;
            cnt_in = cnt_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c8i_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         font_g_ff <= '0;
         font_r_ff <= '0;
         pc_ff <= '0;
         i_ff <= '0;
         sp_ff <= '0;
         si_ff <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         keys_ff <= '0;
         wait_ff <= 1'b0;
         target_ff <= '0;
         rd_ff <= '0;
         exec_ff <= 1'b0;
         disp_valid_ff <= '0;
         for (int k = 0; k < 16; k++) begin
            regs_ff[k] <= '0;
         end
         for (int k = 0; k < STACK_DEPTH; k++) begin
            stack_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         font_g_ff <= font_g_in;
         font_r_ff <= font_r_in;
         pc_ff <= pc_in;
         i_ff <= i_in;
         sp_ff <= sp_in;
         si_ff <= si_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         keys_ff <= keys_in;
         wait_ff <= wait_in;
         target_ff <= target_in;
         rd_ff <= rd_in;
         exec_ff <= exec_in;
         // A result aimed at VF overrides the flag written by the same instruction.
         for (int k = 0; k < 16; k++) begin
            if (reg_we && reg_widx == 4'(k)) begin
               regs_ff[k] <= reg_wdata;
            end else if (flag_we && k == 15) begin
               regs_ff[k] <= {7'd0, flag_wdata};
            end
         end
         if (stack_we) begin
            stack_ff[si_in] <= pc_ff;
         end
         if (disp_clear) begin
            disp_valid_ff <= '0;
         end else if (disp_we) begin
            disp_valid_ff[disp_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rnd_ff <= rnd_in;
      op_hi_ff <= op_hi_in;
      op_lo_ff <= op_lo_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      row_ff <= row_in;
      hit_ff <= hit_in;
      spr_ff <= spr_in;
      cnt_ff <= cnt_in;
   end
endmodule

FILE: hw/rtl/c8i_ram.sv
`timescale 1ns / 1ps
module c8i_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hw/rtl/c8i_alu.sv
`timescale 1ns / 1ps
module c8i_alu (
   input  c8i_pkg::alu_op_type op,
   input  logic [7:0]          a,
   input  logic [7:0]          b,
   output logic [7:0]          res,
   output logic                flag
);
   logic [8:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (op)
         c8i_pkg::ALU_MOV:  begin res = b;              flag = 1'b0;    end
         c8i_pkg::ALU_OR:   begin res = a | b;          flag = 1'b0;    end
         c8i_pkg::ALU_AND:  begin res = a & b;          flag = 1'b0;    end
         c8i_pkg::ALU_XOR:  begin res = a ^ b;          flag = 1'b0;    end
         c8i_pkg::ALU_ADD:  begin res = sum[7:0];       flag = sum[8];  end
         c8i_pkg::ALU_SUB:  begin res = a - b;          flag = a >= b;  end
         c8i_pkg::ALU_SUBN: begin res = b - a;          flag = b >= a;  end
         c8i_pkg::ALU_SHR:  begin res = {1'b0, b[7:1]}; flag = b[0];    end
         default:           begin res = {b[6:0], 1'b0}; flag = b[7];    end
      endcase
   end
endmodule
